// ===== rtl/kls_pkg.sv =====
// ----------------------------------------------------------------------------
// kls_pkg
// Shared sizes, codes and controller/datapath interface types for the
// key list store.
// ----------------------------------------------------------------------------
`default_nettype none

package kls_pkg;

  localparam int DEPTH    = 16;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int KEY_W    = 32;
  localparam int CMD_W    = 3;
  localparam int RPOS_W   = 4;
  localparam int STAT_W   = 2;
  localparam int FPOS_W   = 4;
  localparam int ECNT_W   = 5;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 48;

  localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REVERSE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_MISS   = 2'd2;
  localparam logic [STAT_W-1:0] ST_BEYOND = 2'd3;

  // result staging selections
  localparam logic [2:0] RES_OK     = 3'd0;
  localparam logic [2:0] RES_FULL   = 3'd1;
  localparam logic [2:0] RES_MISS   = 3'd2;
  localparam logic [2:0] RES_FOUND  = 3'd3;
  localparam logic [2:0] RES_READ   = 3'd4;
  localparam logic [2:0] RES_BEYOND = 3'd5;

  // memory read address selections
  localparam logic [1:0] RD_PTR  = 2'd0;
  localparam logic [1:0] RD_PTR1 = 2'd1;
  localparam logic [1:0] RD_HI   = 2'd2;
  localparam logic [1:0] RD_RPOS = 2'd3;

  // memory write selections
  localparam logic [1:0] WR_TAIL   = 2'd0;
  localparam logic [1:0] WR_PTR_RD = 2'd1;
  localparam logic [1:0] WR_HI_TMP = 2'd2;

  typedef struct packed {
    logic       load;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic       tmp_load;
    logic       ptr_clr;
    logic       ptr_inc;
    logic       hi_init;
    logic       hi_dec;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       res_set;
    logic [2:0] res_sel;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             hit;
    logic             ptr_lt_cnt;
    logic             ptr1_lt_cnt;
    logic             lo_lt_hi;
    logic             cnt_gt1;
    logic             rpos_ok;
    logic             out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/kls_ctrl.sv =====
// ----------------------------------------------------------------------------
// kls_ctrl
// Command sequencer: scans, shifts and swaps list entries one memory access
// at a time by driving the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module kls_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  input  kls_pkg::dp_sts_t sts,
  output kls_pkg::dp_cmd_t cmd
);
  import kls_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_SRD   = 4'd2;
  localparam logic [3:0] S_SCMP  = 4'd3;
  localparam logic [3:0] S_SHRD  = 4'd4;
  localparam logic [3:0] S_SHWR  = 4'd5;
  localparam logic [3:0] S_RVA   = 4'd6;
  localparam logic [3:0] S_RVB   = 4'd7;
  localparam logic [3:0] S_RVC   = 4'd8;
  localparam logic [3:0] S_RVD   = 4'd9;
  localparam logic [3:0] S_RDW   = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.cmd)
          CMD_APPEND: begin
            cmd.res_set = 1'b1;
            if (sts.full) begin
              cmd.res_sel = RES_FULL;
            end else begin
              cmd.wr_en   = 1'b1;
              cmd.wr_sel  = WR_TAIL;
              cmd.cnt_inc = 1'b1;
              cmd.res_sel = RES_OK;
            end
            state_next = S_DONE;
          end
          CMD_DELETE, CMD_SEARCH: begin
            cmd.ptr_clr = 1'b1;
            state_next  = S_SRD;
          end
          CMD_REVERSE: begin
            if (sts.cnt_gt1) begin
              cmd.ptr_clr = 1'b1;
              cmd.hi_init = 1'b1;
              state_next  = S_RVA;
            end else begin
              cmd.res_set = 1'b1;
              cmd.res_sel = RES_OK;
              state_next  = S_DONE;
            end
          end
          CMD_READ: begin
            if (sts.rpos_ok) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_RPOS;
              state_next = S_RDW;
            end else begin
              cmd.res_set = 1'b1;
              cmd.res_sel = RES_BEYOND;
              state_next  = S_DONE;
            end
          end
          default: begin
            cmd.res_set = 1'b1;
            cmd.res_sel = RES_OK;
            state_next  = S_DONE;
          end
        endcase
      end
      S_SRD: begin
        if (sts.ptr_lt_cnt) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTR;
          state_next = S_SCMP;
        end else begin
          cmd.res_set = 1'b1;
          cmd.res_sel = RES_MISS;
          state_next  = S_DONE;
        end
      end
      S_SCMP: begin
        if (sts.hit) begin
          cmd.res_set = 1'b1;
          cmd.res_sel = RES_FOUND;
          state_next  = (sts.cmd == CMD_DELETE) ? S_SHRD : S_DONE;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_next  = S_SRD;
        end
      end
      S_SHRD: begin
        if (sts.ptr1_lt_cnt) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTR1;
          state_next = S_SHWR;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_SHWR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_PTR_RD;
        cmd.ptr_inc = 1'b1;
        state_next  = S_SHRD;
      end
      S_RVA: begin
        if (sts.lo_lt_hi) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTR;
          state_next = S_RVB;
        end else begin
          cmd.res_set = 1'b1;
          cmd.res_sel = RES_OK;
          state_next  = S_DONE;
        end
      end
      S_RVB: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RD_HI;
        cmd.tmp_load = 1'b1;
        state_next   = S_RVC;
      end
      S_RVC: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_PTR_RD;
        state_next = S_RVD;
      end
      S_RVD: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_HI_TMP;
        cmd.ptr_inc = 1'b1;
        cmd.hi_dec  = 1'b1;
        state_next  = S_RVA;
      end
      S_RDW: begin
        cmd.res_set = 1'b1;
        cmd.res_sel = RES_READ;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/kls_dp.sv =====
// ----------------------------------------------------------------------------
// kls_dp
// Key memory, entry count, scan pointers, result staging and the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module kls_dp (
  input  wire                         clk,
  input  wire                         rst,
  input  wire  [kls_pkg::IN_W-1:0]    in_data,
  input  kls_pkg::dp_cmd_t            cmd,
  output kls_pkg::dp_sts_t            sts,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [kls_pkg::OUT_W-1:0]   out_data
);
  import kls_pkg::*;

  logic [KEY_W-1:0]  mem [DEPTH];
  logic [KEY_W-1:0]  rdata;
  logic [KEY_W-1:0]  tmp;
  logic [CNT_W-1:0]  count;
  logic [CMD_W-1:0]  cmd_reg;
  logic [KEY_W-1:0]  key_reg;
  logic [RPOS_W-1:0] rpos_reg;
  logic [CNT_W-1:0]  ptr;
  logic [IDX_W-1:0]  hi;
  logic [CNT_W-1:0]  ptr1;
  logic [STAT_W-1:0] res_status;
  logic [FPOS_W-1:0] res_fpos;
  logic [KEY_W-1:0]  res_kout;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  logic [KEY_W-1:0]  wr_data;

  assign ptr1 = ptr + 1'b1;

  always_comb begin
    case (cmd.rd_sel)
      RD_PTR:  rd_addr = ptr[IDX_W-1:0];
      RD_PTR1: rd_addr = ptr1[IDX_W-1:0];
      RD_HI:   rd_addr = hi;
      RD_RPOS: rd_addr = IDX_W'(rpos_reg);
      default: rd_addr = ptr[IDX_W-1:0];
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      WR_TAIL: begin
        wr_addr = count[IDX_W-1:0];
        wr_data = key_reg;
      end
      WR_PTR_RD: begin
        wr_addr = ptr[IDX_W-1:0];
        wr_data = rdata;
      end
      WR_HI_TMP: begin
        wr_addr = hi;
        wr_data = tmp;
      end
      default: begin
        wr_addr = ptr[IDX_W-1:0];
        wr_data = rdata;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_reg  <= in_data[2:0];
      key_reg  <= in_data[34:3];
      rpos_reg <= in_data[38:35];
    end
    if (cmd.tmp_load) begin
      tmp <= rdata;
    end
    if (cmd.ptr_clr) begin
      ptr <= '0;
    end else if (cmd.ptr_inc) begin
      ptr <= ptr1;
    end
    if (cmd.hi_init) begin
      hi <= IDX_W'(count - 1'b1);
    end else if (cmd.hi_dec) begin
      hi <= hi - 1'b1;
    end
    if (cmd.res_set) begin
      case (cmd.res_sel)
        RES_FULL: begin
          res_status <= ST_FULL;
          res_fpos   <= '0;
          res_kout   <= '0;
        end
        RES_MISS: begin
          res_status <= ST_MISS;
          res_fpos   <= '0;
          res_kout   <= '0;
        end
        RES_BEYOND: begin
          res_status <= ST_BEYOND;
          res_fpos   <= '0;
          res_kout   <= '0;
        end
        RES_FOUND: begin
          res_status <= ST_OK;
          res_fpos   <= FPOS_W'(ptr);
          res_kout   <= '0;
        end
        RES_READ: begin
          res_status <= ST_OK;
          res_fpos   <= '0;
          res_kout   <= rdata;
        end
        default: begin
          res_status <= ST_OK;
          res_fpos   <= '0;
          res_kout   <= '0;
        end
      endcase
    end
    if (cmd.out_load) begin
      out_data <= {5'b0, ECNT_W'(count), res_kout, res_fpos, res_status};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        count <= count + 1'b1;
      end else if (cmd.cnt_dec) begin
        count <= count - 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.cmd         = cmd_reg;
    sts.full        = (32'(count) >= 32'(DEPTH));
    sts.hit         = (rdata == key_reg);
    sts.ptr_lt_cnt  = (ptr < count);
    sts.ptr1_lt_cnt = (32'(ptr1) < 32'(count));
    sts.lo_lt_hi    = (ptr[IDX_W-1:0] < hi);
    sts.cnt_gt1     = (count > CNT_W'(1));
    sts.rpos_ok     = (32'(rpos_reg) < 32'(count)) && (32'(rpos_reg) < 32'(DEPTH));
    sts.out_free    = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

// ===== rtl/key_list_store_top.sv =====
// ----------------------------------------------------------------------------
// key_list_store_top
// Ordered list of signed 32-bit keys: append, delete first match, search,
// reverse and read at position, one result per command.
//
// channel   dir  signals                      contents (low bit first)
// s_*       in   s_tvalid s_tready s_tdata    cmd[2:0] key_value[34:3]
//                                             read_position[38:35]
// m_*       out  m_tvalid m_tready m_tdata    status[1:0] found_position[5:2]
//                                             key_out[37:6] entry_count[42:38]
//
// One command is in flight at a time; s_tready is high only while idle.
// Append and unused codes finish without a scan; read does one registered
// read, search reads entries in order, delete also shifts later entries
// down, reverse swaps pairs; each step makes one key memory access.
// Synchronous reset empties the list; key memory contents are not cleared.
// A stalled m_tready holds the result and blocks the next command.
// ----------------------------------------------------------------------------
`default_nettype none

module key_list_store_top (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         s_tvalid,
  output logic                        s_tready,
  input  wire  [kls_pkg::IN_W-1:0]    s_tdata,   // cmd, key_value, read_position
  output logic                        m_tvalid,
  input  wire                         m_tready,
  output logic [kls_pkg::OUT_W-1:0]   m_tdata    // status, found_position,
                                                 // key_out, entry_count
);
  import kls_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  kls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  kls_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_tdata),
    .cmd       (dp_cmd),
    .sts       (dp_sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

`default_nettype wire
